// ----- src/assert_macros.svh -----
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, reset disables it
`define FBPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising clock edge, also during reset
`define FBPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/fbpa_pkg.sv -----
package fbpa_pkg;

    localparam int DEF_MAX_BLOCKS = 64;
    localparam int RST_BLOCKS     = 64;
    localparam int BLK_W          = 6;
    localparam int TASK_W         = 8;
    localparam int CNT_W          = 7;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_REL     = 2'd1,
        CMD_REL_ALL = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]        command;
        logic [TASK_W-1:0] owner_task;
        logic [BLK_W-1:0]  block_index;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] granted_block;
        logic [CNT_W-1:0] free_count;
    } t_rsp;

    // per-cycle control of a chain of cells
    typedef struct packed {
        logic ld;
        logic shift;
        logic wr;
    } t_cell_ctl;

endpackage

// ----- src/fbpa_cell.sv -----
module fbpa_cell #(
    parameter int W        = 8,
    parameter int LOAD_VAL = 0
) (
    input  logic                 i_clk,
    input  fbpa_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_sel,
    input  logic [W-1:0]         i_wdata,
    input  logic [W-1:0]         i_next,
    output logic [W-1:0]         o_data
);
    import fbpa_pkg::*;

    logic [W-1:0] r_data;

    // load wins over write, write wins over shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_data <= W'(LOAD_VAL);
        end else if (i_ctl.wr && i_sel) begin
            r_data <= i_wdata;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

// ----- src/fbpa_chain.sv -----
module fbpa_chain #(
    parameter int N = 64,
    parameter int W = 8
) (
    input  logic                  i_clk,
    input  fbpa_pkg::t_cell_ctl   i_ctl,
    input  logic [$clog2(N)-1:0]  i_pos,
    input  logic [W-1:0]          i_wdata,
    output logic [W-1:0]          o_head
);
    import fbpa_pkg::*;

    logic [W-1:0] w_data [N];

    // row of cells, each shifting toward the head
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [W-1:0] w_next;
        if (g == N - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        fbpa_cell #(.W(W), .LOAD_VAL(g)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_sel   (i_pos == ($clog2(N))'(g)),
            .i_wdata (i_wdata),
            .i_next  (w_next),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

// ----- src/fixed_block_pool_allocator_core.sv -----
// Fixed-size block pool allocator. Blocks are named by index; free blocks
// sit in a FIFO chain of cells, allocated blocks in a second chain kept in
// allocation order with their owner task. Allocate and query go straight
// to the finish state and register their response there once the output
// is not stalled. Release and release-all rotate the allocated chain one
// cell per cycle through every allocated block (at most MAX_BLOCKS). One
// request is worked at a time; a new one is taken while the last response
// still waits. Writing block_count rebuilds the pool.
module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fbpa_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output fbpa_pkg::t_rsp o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import fbpa_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = IW + TASK_W;
    localparam int RST_CNT = (MAX_BLOCKS < RST_BLOCKS) ? MAX_BLOCKS : RST_BLOCKS;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_free_cnt, n_free_cnt;
    logic [CW-1:0]     r_used_cnt, n_used_cnt;
    logic [CW-1:0]     r_steps, n_steps;
    logic [1:0]        r_cmd, n_cmd;
    logic [TASK_W-1:0] r_task, n_task;
    logic [BLK_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found;
    logic [1:0]        r_status, n_status;
    logic [BLK_W-1:0]  r_granted, n_granted;
    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;

    t_cell_ctl         w_fctl, w_uctl;
    logic [IW-1:0]     w_fpos, w_upos;
    logic [IW-1:0]     w_fwdata;
    logic [EW-1:0]     w_uwdata;
    logic [IW-1:0]     w_fhead;
    logic [EW-1:0]     w_uhead;
    logic              w_cfg_wr;
    logic [6:0]        w_cfg_v;
    logic [CW-1:0]     w_cfg_cnt;
    logic              w_match;

    // config write and clamp
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign w_cfg_v  = pwdata[6:0];
    always_comb begin
        if (w_cfg_v == 7'd0) begin
            w_cfg_cnt = CW'(1);
        end else if (32'(w_cfg_v) > 32'(MAX_BLOCKS)) begin
            w_cfg_cnt = CW'(MAX_BLOCKS);
        end else begin
            w_cfg_cnt = CW'(w_cfg_v);
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_count) : 32'd0;

    // free and allocated chains
    fbpa_chain #(.N(MAX_BLOCKS), .W(IW)) u_free (
        .i_clk   (i_clk),
        .i_ctl   (w_fctl),
        .i_pos   (w_fpos),
        .i_wdata (w_fwdata),
        .o_head  (w_fhead)
    );

    fbpa_chain #(.N(MAX_BLOCKS), .W(EW)) u_used (
        .i_clk   (i_clk),
        .i_ctl   (w_uctl),
        .i_pos   (w_upos),
        .i_wdata (w_uwdata),
        .o_head  (w_uhead)
    );

    assign w_match = (r_cmd == CMD_REL)
        ? (16'(w_uhead[IW-1:0]) == 16'(r_idx))
        : (w_uhead[EW-1:IW] == r_task);

    // sequencer: next state, chain controls and response
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_free_cnt = r_free_cnt;
        n_used_cnt = r_used_cnt;
        n_steps    = r_steps;
        n_cmd      = r_cmd;
        n_task     = r_task;
        n_idx      = r_idx;
        n_found    = r_found;
        n_status   = r_status;
        n_granted  = r_granted;
        n_valid    = r_valid && i_stall;
        n_rsp      = r_rsp;
        w_fctl     = '0;
        w_uctl     = '0;
        w_fpos     = r_free_cnt[IW-1:0];
        w_upos     = r_used_cnt[IW-1:0];
        w_fwdata   = w_uhead[IW-1:0];
        w_uwdata   = w_uhead;
        o_stall    = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd     = i_req.command;
                    n_task    = i_req.owner_task;
                    n_idx     = i_req.block_index;
                    n_found   = 1'b0;
                    n_status  = ST_OK;
                    n_granted = '0;
                    n_steps   = r_used_cnt;
                    case (i_req.command)
                        CMD_ALLOC: begin
                            n_state = S_FIN;
                            if (r_free_cnt == '0) begin
                                n_status = ST_NO_FREE;
                            end else begin
                                n_granted    = BLK_W'(w_fhead);
                                w_fctl.shift = 1'b1;
                                w_uctl.wr    = 1'b1;
                                w_uwdata     = {i_req.owner_task, w_fhead};
                                n_free_cnt   = r_free_cnt - CW'(1);
                                n_used_cnt   = r_used_cnt + CW'(1);
                            end
                        end
                        CMD_REL, CMD_REL_ALL: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_steps == '0) begin
                    n_state = S_FIN;
                    if (r_cmd == CMD_REL && !r_found) begin
                        n_status = ST_NOT_ALLOC;
                    end
                end else begin
                    // rotate head cell out, keep it at the tail or free it
                    n_steps      = r_steps - CW'(1);
                    w_uctl.shift = 1'b1;
                    w_upos       = IW'(r_used_cnt - CW'(1));
                    if (w_match) begin
                        n_found    = 1'b1;
                        n_used_cnt = r_used_cnt - CW'(1);
                        w_fctl.wr  = 1'b1;
                        n_free_cnt = r_free_cnt + CW'(1);
                    end else begin
                        w_uctl.wr  = 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!r_valid || !i_stall) begin
                    n_valid = 1'b1;
                    n_rsp   = '{status: r_status, granted_block: r_granted,
                                free_count: CNT_W'(r_free_cnt)};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // rebuild on reset or block_count write
        if (!i_rst_n || w_cfg_wr) begin
            w_fctl.ld = 1'b1;
            w_uctl.ld = 1'b1;
        end
        if (w_cfg_wr) begin
            n_count    = w_cfg_cnt;
            n_free_cnt = w_cfg_cnt;
            n_used_cnt = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= CW'(RST_CNT);
            r_free_cnt <= CW'(RST_CNT);
            r_used_cnt <= '0;
            r_steps    <= '0;
            r_found    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_free_cnt <= n_free_cnt;
            r_used_cnt <= n_used_cnt;
            r_steps    <= n_steps;
            r_found    <= n_found;
            r_valid    <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_task    <= n_task;
        r_idx     <= n_idx;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_rsp     <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `FBPA_ASSERT(a_cnt_sum, i_clk, i_rst_n, (r_state == S_IDLE) |-> (({1'b0, r_free_cnt} + {1'b0, r_used_cnt}) == {1'b0, r_count}), "free plus allocated differs from block count")
    `FBPA_ASSERT(a_walk_bound, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_steps <= r_used_cnt), "walk longer than allocated chain")
    `FBPA_ASSERT(a_free_bound, i_clk, i_rst_n, (r_free_cnt <= r_count), "free count above block count")

endmodule
